// ===== hw/rtl/lpsc_pkg.sv =====
package lpsc_pkg;

  localparam int BYTE_W = 8;
  localparam int CAP_W = 24;
  localparam int LEN_W = 32;
  localparam int CODE_W = 2;
  localparam int CNT_W = 3;
  localparam int START_CODE_LEN = 4;

  // register indexes
  localparam logic REG_LENGTH_CODE = 1'b0;
  localparam logic REG_OUT_CAPACITY = 1'b1;

  // prefix width codes
  localparam logic [CODE_W-1:0] LC_1BYTE = 2'd0;
  localparam logic [CODE_W-1:0] LC_2BYTE = 2'd1;
  localparam logic [CODE_W-1:0] LC_4BYTE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_OVFL  = 2'd2
  } status_t;

  // results caused by one input item
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;    // number of results, 0..4
    logic              sc;     // results are the start code
    logic [BYTE_W-1:0] data;   // payload byte
    logic              bv;     // byte carries data
    logic              last;   // final result closes the access unit
    status_t           status;
    logic [CAP_W-1:0]  total;
  } grp_t;

endpackage

// ===== hw/rtl/lpsc_core.sv =====
module lpsc_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [lpsc_pkg::BYTE_W-1:0]    step_byte,
  input  logic                           step_last,
  input  logic [lpsc_pkg::CODE_W-1:0]    length_code,
  input  logic [lpsc_pkg::CAP_W-1:0]     out_capacity,
  output lpsc_pkg::grp_t                 grp
);

  logic                          inp_r, inp_nxt;
  logic [1:0]                    pc_r, pc_nxt;
  logic [lpsc_pkg::LEN_W-1:0]    acc_r, acc_nxt;
  logic [lpsc_pkg::LEN_W-1:0]    pl_r, pl_nxt;
  logic [lpsc_pkg::CAP_W-1:0]    wc_r, wc_nxt;
  logic                          ovf_r, ovf_nxt;

  logic [lpsc_pkg::CAP_W-1:0]    space;
  logic [lpsc_pkg::CAP_W-1:0]    space_after_sc;
  logic [lpsc_pkg::LEN_W-1:0]    acc;
  logic                          prefix_done;

  assign space = (out_capacity > wc_r) ? (out_capacity - wc_r) : '0;
  assign space_after_sc = space - lpsc_pkg::CAP_W'(lpsc_pkg::START_CODE_LEN);
  assign acc = {acc_r[lpsc_pkg::LEN_W-lpsc_pkg::BYTE_W-1:0], step_byte};

  always_comb begin
    unique case (length_code)
      lpsc_pkg::LC_1BYTE: prefix_done = 1'b1;
      lpsc_pkg::LC_2BYTE: prefix_done = (pc_r != 2'd0);
      default:            prefix_done = (pc_r == 2'd3);
    endcase
  end

  always_comb begin
    inp_nxt = inp_r;
    pc_nxt  = pc_r;
    acc_nxt = acc_r;
    pl_nxt  = pl_r;
    wc_nxt  = wc_r;
    ovf_nxt = ovf_r;
    grp     = '0;
    grp.status = lpsc_pkg::ST_OK;

    if (!ovf_r) begin
      if (inp_r) begin
        if (space == '0) begin
          ovf_nxt = 1'b1;
        end else begin
          grp.cnt  = lpsc_pkg::CNT_W'(1);
          grp.data = step_byte;
          grp.bv   = 1'b1;
          wc_nxt   = wc_r + lpsc_pkg::CAP_W'(1);
          pl_nxt   = pl_r - lpsc_pkg::LEN_W'(1);
          if (pl_r == lpsc_pkg::LEN_W'(1)) begin
            inp_nxt = 1'b0;
          end
        end
      end else if (prefix_done) begin
        acc_nxt = '0;
        pc_nxt  = '0;
        if (space < lpsc_pkg::CAP_W'(lpsc_pkg::START_CODE_LEN)) begin
          ovf_nxt = 1'b1;
        end else begin
          grp.cnt = lpsc_pkg::CNT_W'(lpsc_pkg::START_CODE_LEN);
          grp.sc  = 1'b1;
          grp.bv  = 1'b1;
          wc_nxt  = wc_r + lpsc_pkg::CAP_W'(lpsc_pkg::START_CODE_LEN);
          if (acc > lpsc_pkg::LEN_W'(space_after_sc)) begin
            ovf_nxt = 1'b1;
          end else if (acc != '0) begin
            inp_nxt = 1'b1;
            pl_nxt  = acc;
          end
        end
      end else begin
        acc_nxt = acc;
        pc_nxt  = pc_r + 2'd1;
      end
    end

    if (step_last) begin
      if (ovf_nxt) begin
        grp.status = lpsc_pkg::ST_OVFL;
      end else if (inp_nxt || pc_nxt != 2'd0) begin
        grp.status = lpsc_pkg::ST_TRUNC;
      end else begin
        grp.status = lpsc_pkg::ST_OK;
      end
      if (grp.cnt == '0) begin
        grp.cnt  = lpsc_pkg::CNT_W'(1);
        grp.bv   = 1'b0;
        grp.data = '0;
      end
      grp.last  = 1'b1;
      grp.total = wc_nxt;
      inp_nxt = 1'b0;
      pc_nxt  = '0;
      acc_nxt = '0;
      pl_nxt  = '0;
      wc_nxt  = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_r <= 1'b0;
      pc_r  <= '0;
      acc_r <= '0;
      pl_r  <= '0;
      wc_r  <= '0;
      ovf_r <= 1'b0;
    end else if (step) begin
      inp_r <= inp_nxt;
      pc_r  <= pc_nxt;
      acc_r <= acc_nxt;
      pl_r  <= pl_nxt;
      wc_r  <= wc_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ===== hw/rtl/length_prefixed_to_start_code_units_unit.sv =====
// Converts length-prefixed NAL units (1, 2 or 4 byte big-endian prefix) into
// start-code form (00 00 00 01). Each input item passes an input register,
// one pass of conversion logic and a result register that holds the up to
// four results it causes. Payload bytes flow at one item per cycle while the
// output accepts them; a byte that completes a prefix and fits in the output
// capacity holds the result register until the four start code bytes are taken,
// so the next item waits; other prefix bytes give no result. The last result of
// each access unit carries status and output byte count; an access unit that
// ends with no result this step gets a status-only item.
module length_prefixed_to_start_code_units_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpsc_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          in_unit_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpsc_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_byte_valid,
  output logic                          out_run_last,
  output logic [1:0]                    out_status,
  output logic [lpsc_pkg::CAP_W-1:0]    out_total_bytes,
  input  logic                          cfg_wen,
  input  logic                          cfg_index,
  input  logic [lpsc_pkg::CAP_W-1:0]    cfg_wdata
);

  logic [lpsc_pkg::CODE_W-1:0]  length_code_r;
  logic [lpsc_pkg::CAP_W-1:0]   out_capacity_r;

  logic                         iv_r;
  logic [lpsc_pkg::BYTE_W-1:0]  ibyte_r;
  logic                         ilast_r;

  lpsc_pkg::grp_t               grp_r, grp_nxt, step_grp;
  logic                         grp_free;
  logic                         move;
  logic                         out_fire;

  assign out_fire = out_valid && out_ready;
  assign grp_free = (grp_r.cnt == '0) ||
                    (grp_r.cnt == lpsc_pkg::CNT_W'(1) && out_ready);
  assign move     = iv_r && grp_free;
  assign in_ready = !iv_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_code_r  <= lpsc_pkg::LC_4BYTE;
      out_capacity_r <= '1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        lpsc_pkg::REG_LENGTH_CODE:  length_code_r <= cfg_wdata[lpsc_pkg::CODE_W-1:0];
        lpsc_pkg::REG_OUT_CAPACITY: out_capacity_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_ready) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ibyte_r <= in_byte;
      ilast_r <= in_unit_last;
    end
  end

  lpsc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (move),
    .step_byte    (ibyte_r),
    .step_last    (ilast_r),
    .length_code  (length_code_r),
    .out_capacity (out_capacity_r),
    .grp          (step_grp)
  );

  always_comb begin
    grp_nxt = grp_r;
    if (move) begin
      grp_nxt = step_grp;
    end else if (out_fire) begin
      grp_nxt.cnt = grp_r.cnt - lpsc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r <= '0;
    end else begin
      grp_r <= grp_nxt;
    end
  end

  assign out_valid       = (grp_r.cnt != '0);
  assign out_run_last    = grp_r.last && (grp_r.cnt == lpsc_pkg::CNT_W'(1));
  assign out_byte_valid  = grp_r.bv;
  assign out_byte        = grp_r.sc ?
                           ((grp_r.cnt == lpsc_pkg::CNT_W'(1)) ? 8'h01 : 8'h00) :
                           grp_r.data;
  assign out_status      = out_run_last ? grp_r.status : lpsc_pkg::ST_OK;
  assign out_total_bytes = out_run_last ? grp_r.total : '0;

  a_grp_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    grp_r.cnt <= lpsc_pkg::CNT_W'(lpsc_pkg::START_CODE_LEN))
    else $error("result count out of range");

  a_status_only_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> out_run_last)
    else $error("status-only item not last of access unit");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (iv_r && !move) |=> (iv_r && $stable(ibyte_r) && $stable(ilast_r)))
    else $error("pending item lost");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && grp_r.cnt == lpsc_pkg::CNT_W'(1) && !move) |=> !out_valid)
    else $error("result repeated after last of group");

endmodule
